@@ hw/rtl/equal_distinct_histogram_engine_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the equal-distinct histogram engine
// Same-cycle and next-cycle implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef EQUAL_DISTINCT_HISTOGRAM_ENGINE_UNIT_ASSERT_SVH
`define EQUAL_DISTINCT_HISTOGRAM_ENGINE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define EDH_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edh same-cycle check failed");

// antecedent implies consequent in the next cycle
`define EDH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edh next-cycle check failed");

`endif

@@ hw/rtl/edh_pkg.sv @@
// ----------------------------------------------------------------------------
// edh_pkg
// Shared types, constants and helpers of the histogram engine.
// ----------------------------------------------------------------------------
`default_nettype none

package edh_pkg;

  localparam int unsigned BUCKET_SLOTS = 256;
  localparam int unsigned MAX_VALUES  = 65536;
  localparam int unsigned IDX_W   = $clog2(BUCKET_SLOTS);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned DIST_W  = 17;
  localparam int unsigned ROWS_W  = 48;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned OCC_W   = 32;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned DIV_STEPS = DIST_W;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_CONTAIN = 3'd1,
    OP_LOWER   = 3'd2,
    OP_UPPER   = 3'd3,
    OP_TOTALS  = 3'd4,
    OP_CLEAR   = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_CLOSE  = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_TOTALS = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_DISTINCT_TOTAL = 1'b0,
    CFG_BUCKET_LIMIT   = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_LOAD,
    S_SRCH,
    S_CMP,
    S_ANSWER,
    S_TOTALS
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic clear;
    logic build_start;
    logic div_step;
    logic load_do;
    logic search_init;
    logic rd_mid;
    logic rd_idx;
    logic srch_step;
    logic emit_answer;
    logic emit_totals;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       load_skip;
    logic       load_closes;
    logic       div_done;
    logic       lo_lt_hi;
    logic       out_free;
  } status_t;

  // 48-bit saturating add
  function automatic logic [ROWS_W-1:0] sat_add48(input logic [ROWS_W-1:0] a,
                                                  input logic [ROWS_W-1:0] b);
    logic [ROWS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ROWS_W] ? {ROWS_W{1'b1}} : s[ROWS_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/edh_ifs.sv @@
// ----------------------------------------------------------------------------
// edh channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface edh_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic signed [63:0] value;
  logic [31:0] occurrences;

  modport source (output valid, output opcode, output value, output occurrences,
                  input ready);
  modport sink (input valid, input opcode, input value, input occurrences,
                output ready);
endinterface

interface edh_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        found;
  logic [7:0]  bucket_id;
  logic signed [63:0] bucket_low;
  logic signed [63:0] bucket_high;
  logic [47:0] bucket_rows;
  logic [16:0] bucket_distinct;
  logic [47:0] total_rows;
  logic [16:0] total_distinct;

  modport source (output valid, output kind, output found, output bucket_id,
                  output bucket_low, output bucket_high, output bucket_rows,
                  output bucket_distinct, output total_rows, output total_distinct,
                  input ready);
  modport sink (input valid, input kind, input found, input bucket_id,
                input bucket_low, input bucket_high, input bucket_rows,
                input bucket_distinct, input total_rows, input total_distinct,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/equal_distinct_histogram_engine_unit.sv @@
// ----------------------------------------------------------------------------
// equal_distinct_histogram_engine_unit
// Load: decode, then the load step that registers any closed-bucket result; the
//   first load of a build first runs the divide state (17 one-bit restoring steps and a done step).
// Lookup: binary search over the closed buckets, with one
//   registered store read per binary-search step. Totals waits for a free output register; clear needs none.
// One item at a time. Reset (rst, synchronous) empties the histogram and sets
//   distinct_total to 1 and bucket_limit to 256; bucket stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module equal_distinct_histogram_engine_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  edh_req_if.sink                        req,
  edh_rsp_if.source                      rsp,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_index,
  input  wire logic [edh_pkg::CFG_W-1:0] cfg_data
);
  import edh_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign req.ready = in_ready;

  // sequencer
  edh_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  edh_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_opcode           (req.opcode),
    .in_value            (req.value),
    .in_occurrences      (req.occurrences),
    .out_valid           (rsp.valid),
    .out_ready           (rsp.ready),
    .out_kind            (rsp.kind),
    .out_found           (rsp.found),
    .out_bucket_id       (rsp.bucket_id),
    .out_bucket_low      (rsp.bucket_low),
    .out_bucket_high     (rsp.bucket_high),
    .out_bucket_rows     (rsp.bucket_rows),
    .out_bucket_distinct (rsp.bucket_distinct),
    .out_total_rows      (rsp.total_rows),
    .out_total_distinct  (rsp.total_distinct)
  );

  // checks
`include "equal_distinct_histogram_engine_unit_assert.svh"
  `EDH_ASSERT_NEXT(a_busy_after_xfer, clk, rst, req.valid && req.ready, !req.ready)
  `EDH_ASSERT_SAME(a_totals_no_bucket, clk, rst, rsp.valid && rsp.kind == KIND_TOTALS, !rsp.found)
  `EDH_ASSERT_SAME(a_close_nonempty, clk, rst, rsp.valid && rsp.kind == KIND_CLOSE, rsp.found && rsp.bucket_distinct != '0)

endmodule

`default_nettype wire

@@ hw/rtl/edh_datapath.sv @@
// ----------------------------------------------------------------------------
// edh_datapath
// Config registers, build state, divider, bucket stores, search and output.
// ----------------------------------------------------------------------------
`default_nettype none

module edh_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire edh_pkg::cmd_t                cmd,
  output edh_pkg::status_t                  status,
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_index,
  input  wire logic [edh_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic [2:0]                   in_opcode,
  input  wire logic signed [63:0]           in_value,
  input  wire logic [31:0]                  in_occurrences,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_kind,
  output logic                              out_found,
  output logic [7:0]                        out_bucket_id,
  output logic signed [63:0]                out_bucket_low,
  output logic signed [63:0]                out_bucket_high,
  output logic [47:0]                       out_bucket_rows,
  output logic [16:0]                       out_bucket_distinct,
  output logic [47:0]                       out_total_rows,
  output logic [16:0]                       out_total_distinct
);
  import edh_pkg::*;

  // latched item
  logic [2:0]              op;
  logic signed [VAL_W-1:0] value;
  logic [OCC_W-1:0]        occ;

  // config
  logic [DIST_W-1:0] distinct_total;
  logic [CNT_W-1:0]  bucket_limit;

  // build state
  logic [CNT_W-1:0]  buckets_closed;
  logic [CNT_W-1:0]  bucket_goal;
  logic [DIST_W-1:0] per_bucket_share;   // divider quotient/dividend register
  logic [CNT_W-1:0]  extra_buckets;      // divider remainder register
  logic [CNT_W-1:0]  divisor;
  logic [4:0]        div_cnt;
  logic [DIST_W-1:0] values_in_open;
  logic [ROWS_W-1:0] open_rows;
  logic signed [VAL_W-1:0] open_low;
  logic [ROWS_W-1:0] grand_rows;

  // search
  logic [CNT_W-1:0] lo, hi;

  // stores
  logic signed [VAL_W-1:0] low_store  [BUCKET_SLOTS];
  logic signed [VAL_W-1:0] high_store [BUCKET_SLOTS];
  logic [ROWS_W-1:0]       rows_store [BUCKET_SLOTS];
  logic signed [VAL_W-1:0] low_rd, high_rd;
  logic [ROWS_W-1:0]       rows_rd;

  // build start values
  logic [DIST_W-1:0] dt_sat;
  logic [CNT_W-1:0]  bl_sat;
  logic [CNT_W-1:0]  goal_new;
  always_comb begin
    dt_sat = (distinct_total > DIST_W'(MAX_VALUES)) ? DIST_W'(MAX_VALUES) : distinct_total;
    if (bucket_limit == '0) begin
      bl_sat = CNT_W'(1);
    end else if (bucket_limit > CNT_W'(BUCKET_SLOTS)) begin
      bl_sat = CNT_W'(BUCKET_SLOTS);
    end else begin
      bl_sat = bucket_limit;
    end
    goal_new = (dt_sat < DIST_W'(bl_sat)) ? dt_sat[CNT_W-1:0] : bl_sat;
  end

  // restoring divider step
  logic [CNT_W:0] rem_sh;
  logic           rem_ge;
  assign rem_sh = {extra_buckets, per_bucket_share[DIST_W-1]};
  assign rem_ge = rem_sh >= {1'b0, divisor};

  // load arithmetic
  logic [DIST_W-1:0] size_cur, vio_inc;
  logic [ROWS_W-1:0] rows_new;
  logic              closes;
  assign size_cur = per_bucket_share +
                    DIST_W'((buckets_closed < extra_buckets) ? 1'b1 : 1'b0);
  assign vio_inc  = values_in_open + DIST_W'(1);
  assign closes   = vio_inc >= size_cur;
  assign rows_new = sat_add48((values_in_open == '0) ? '0 : open_rows, ROWS_W'(occ));

  // search arithmetic
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic             go_right;
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CNT_W:1];
  assign go_right = (op == OP_UPPER) ? !(value < high_rd) : (high_rd < value);

  // answer
  logic              lo_valid, hit;
  logic [DIST_W-1:0] size_lo;
  assign lo_valid = lo < buckets_closed;
  assign hit      = lo_valid &&
                    ((op != OP_CONTAIN) || (!(value < low_rd) && !(high_rd < value)));
  assign size_lo  = per_bucket_share + DIST_W'((lo < extra_buckets) ? 1'b1 : 1'b0);

  // totals
  logic [DIST_W+CNT_W-1:0] share_prod;
  logic [CNT_W-1:0]        ex_min;
  logic [DIST_W+CNT_W-1:0] dist_sum;
  assign share_prod = per_bucket_share * buckets_closed;
  assign ex_min     = (extra_buckets < buckets_closed) ? extra_buckets : buckets_closed;
  assign dist_sum   = share_prod + (DIST_W+CNT_W)'(ex_min);

  // status
  logic out_free;
  assign out_free = !out_valid || out_ready;
  always_comb begin
    status.op          = op;
    status.empty       = (buckets_closed == '0) && (values_in_open == '0);
    status.load_skip   = buckets_closed >= bucket_goal;
    status.load_closes = closes;
    status.div_done    = div_cnt == '0;
    status.lo_lt_hi    = lo < hi;
    status.out_free    = out_free;
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op    <= in_opcode;
      value <= in_value;
      occ   <= in_occurrences;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      distinct_total <= DIST_W'(1);
      bucket_limit   <= CNT_W'(BUCKET_SLOTS);
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DISTINCT_TOTAL: distinct_total <= cfg_data;
        CFG_BUCKET_LIMIT:   bucket_limit   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // build state and divider
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      buckets_closed   <= '0;
      bucket_goal      <= '0;
      per_bucket_share <= '0;
      extra_buckets    <= '0;
      divisor          <= '0;
      div_cnt          <= '0;
      values_in_open   <= '0;
      open_rows        <= '0;
      open_low         <= '0;
      grand_rows       <= '0;
    end else begin
      if (cmd.build_start) begin
        bucket_goal      <= goal_new;
        divisor          <= goal_new;
        extra_buckets    <= '0;
        per_bucket_share <= (goal_new == '0) ? '0 : dt_sat;
        div_cnt          <= (goal_new == '0) ? 5'd0 : 5'(DIV_STEPS);
      end
      if (cmd.div_step && div_cnt != '0) begin
        per_bucket_share <= {per_bucket_share[DIST_W-2:0], rem_ge};
        extra_buckets    <= rem_ge ? CNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[CNT_W-1:0];
        div_cnt          <= div_cnt - 5'd1;
      end
      if (cmd.load_do) begin
        if (values_in_open == '0) begin
          open_low <= value;
        end
        if (closes) begin
          buckets_closed <= buckets_closed + CNT_W'(1);
          values_in_open <= '0;
          open_rows      <= '0;
          grand_rows     <= sat_add48(grand_rows, rows_new);
        end else begin
          values_in_open <= vio_inc;
          open_rows      <= rows_new;
        end
      end
    end
  end

  // bucket stores: one write port, one registered read port
  logic [IDX_W-1:0] wr_addr, rd_addr;
  assign wr_addr = buckets_closed[IDX_W-1:0];
  assign rd_addr = cmd.rd_mid ? mid[IDX_W-1:0] : lo[IDX_W-1:0];
  always_ff @(posedge clk) begin
    if (cmd.load_do && closes) begin
      low_store[wr_addr]  <= (values_in_open == '0) ? value : open_low;
      high_store[wr_addr] <= value;
      rows_store[wr_addr] <= rows_new;
    end
    if (cmd.rd_mid || cmd.rd_idx) begin
      low_rd  <= low_store[rd_addr];
      high_rd <= high_store[rd_addr];
      rows_rd <= rows_store[rd_addr];
    end
  end

  // binary search bounds
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo <= '0;
      hi <= buckets_closed;
    end else if (cmd.srch_step) begin
      if (go_right) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
  end

  // output register
  logic emit_close;
  assign emit_close = cmd.load_do && closes;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_close || cmd.emit_answer || cmd.emit_totals) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_close) begin
      out_kind            <= KIND_CLOSE;
      out_found           <= 1'b1;
      out_bucket_id       <= buckets_closed[IDX_W-1:0];
      out_bucket_low      <= (values_in_open == '0) ? value : open_low;
      out_bucket_high     <= value;
      out_bucket_rows     <= rows_new;
      out_bucket_distinct <= size_cur;
      out_total_rows      <= '0;
      out_total_distinct  <= '0;
    end else if (cmd.emit_answer) begin
      out_kind            <= KIND_LOOKUP;
      out_found           <= hit;
      out_bucket_id       <= hit ? lo[IDX_W-1:0] : '0;
      out_bucket_low      <= hit ? low_rd : '0;
      out_bucket_high     <= hit ? high_rd : '0;
      out_bucket_rows     <= hit ? rows_rd : '0;
      out_bucket_distinct <= hit ? size_lo : '0;
      out_total_rows      <= '0;
      out_total_distinct  <= '0;
    end else if (cmd.emit_totals) begin
      out_kind            <= KIND_TOTALS;
      out_found           <= 1'b0;
      out_bucket_id       <= '0;
      out_bucket_low      <= '0;
      out_bucket_high     <= '0;
      out_bucket_rows     <= '0;
      out_bucket_distinct <= '0;
      out_total_rows      <= grand_rows;
      out_total_distinct  <= dist_sum[DIST_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/edh_controller.sv @@
// ----------------------------------------------------------------------------
// edh_controller
// Sequencer: decode, build division, load, binary search and result issue.
// ----------------------------------------------------------------------------
`default_nettype none

module edh_controller (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire edh_pkg::status_t status,
  output edh_pkg::cmd_t         cmd
);
  import edh_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = (state == S_IDLE);
    cmd.latch_in = in_valid && in_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (status.op == OP_LOAD) begin
          if (status.empty) begin
            cmd.build_start = 1'b1;
            state_next      = S_DIV;
          end else begin
            state_next = S_LOAD;
          end
        end else if (status.op == OP_CONTAIN || status.op == OP_LOWER ||
                     status.op == OP_UPPER) begin
          cmd.search_init = 1'b1;
          state_next      = S_SRCH;
        end else if (status.op == OP_TOTALS) begin
          state_next = S_TOTALS;
        end else if (status.op == OP_CLEAR) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        priority if (status.load_skip) begin
          state_next = S_IDLE;
        end else if (!status.load_closes || status.out_free) begin
          cmd.load_do = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_SRCH: begin
        if (status.lo_lt_hi) begin
          cmd.rd_mid = 1'b1;
          state_next = S_CMP;
        end else begin
          cmd.rd_idx = 1'b1;
          state_next = S_ANSWER;
        end
      end
      S_CMP: begin
        cmd.srch_step = 1'b1;
        state_next    = S_SRCH;
      end
      S_ANSWER: begin
        if (status.out_free) begin
          cmd.emit_answer = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_TOTALS: begin
        if (status.out_free) begin
          cmd.emit_totals = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ bench/edh_checker.sv @@
// ----------------------------------------------------------------------------
// edh_checker
// Watches the request, response and configuration ports of the histogram
// engine, predicts each result from its own model of the bucket build, and
// compares every response transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module edh_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  edh_req_if                             req,
  edh_rsp_if                             rsp,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_index,
  input  wire logic [edh_pkg::CFG_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);
  import edh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t              kind;
    logic               found;
    logic [7:0]         bucket_id;
    logic signed [63:0] bucket_low;
    logic signed [63:0] bucket_high;
    logic [47:0]        bucket_rows;
    logic [16:0]        bucket_distinct;
    logic [47:0]        total_rows;
    logic [16:0]        total_distinct;
  } hist_result_t;

  // configuration as last written
  logic [16:0] distinct_total_reg;
  logic [8:0]  bucket_limit_reg;

  // histogram model
  logic signed [63:0] low_st  [BUCKET_SLOTS];
  logic signed [63:0] high_st [BUCKET_SLOTS];
  logic [47:0]        rows_st [BUCKET_SLOTS];
  int unsigned        closed, goal, share, extra, in_open;
  logic [47:0]        open_rows, grand_rows;
  logic signed [63:0] open_low;

  hist_result_t expected_results[$];

  function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

  function automatic int unsigned values_in_bucket(int unsigned idx);
    return share + ((idx < extra) ? 1 : 0);
  endfunction

  function automatic void clear_model();
    closed = 0; goal = 0; share = 0; extra = 0; in_open = 0;
    open_rows = '0; open_low = '0; grand_rows = '0;
  endfunction

  function automatic void report_bucket(ref hist_result_t r, input int unsigned idx);
    r.found           = 1'b1;
    r.bucket_id       = idx[7:0];
    r.bucket_low      = low_st[idx];
    r.bucket_high     = high_st[idx];
    r.bucket_rows     = rows_st[idx];
    r.bucket_distinct = 17'(values_in_bucket(idx));
  endfunction

  // returns 1 when the item yields a result
  function automatic bit predict_histogram(logic [2:0] op, logic signed [63:0] val,
                                           logic [31:0] occ, ref hist_result_t r);
    int unsigned dt, bl, g, lo, hi, mid, ex;
    bit go_right;
    r = '0;
    case (op)
      OP_LOAD: begin
        // first load into an empty histogram latches the bucket plan
        if (closed == 0 && in_open == 0) begin
          dt = (distinct_total_reg > MAX_VALUES) ? MAX_VALUES : distinct_total_reg;
          bl = (bucket_limit_reg == 0) ? 1 : bucket_limit_reg;
          if (bl > BUCKET_SLOTS) bl = BUCKET_SLOTS;
          g = (dt < bl) ? dt : bl;
          goal  = g;
          share = g ? dt / g : 0;
          extra = g ? dt % g : 0;
        end
        if (closed >= goal) return 0;
        if (in_open == 0) begin
          open_low  = val;
          open_rows = '0;
        end
        open_rows = add_sat48(open_rows, {16'd0, occ});
        in_open++;
        if (in_open >= values_in_bucket(closed)) begin
          low_st[closed]  = open_low;
          high_st[closed] = val;
          rows_st[closed] = open_rows;
          grand_rows = add_sat48(grand_rows, open_rows);
          r.kind = KIND_CLOSE;
          report_bucket(r, closed);
          closed++;
          in_open   = 0;
          open_rows = '0;
          return 1;
        end
        return 0;
      end
      OP_CONTAIN, OP_LOWER, OP_UPPER: begin
        // binary search over the maxima of closed buckets
        lo = 0;
        hi = closed;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          go_right = (op == OP_UPPER) ? !(val < high_st[mid]) : (high_st[mid] < val);
          if (go_right) lo = mid + 1;
          else hi = mid;
        end
        r.kind = KIND_LOOKUP;
        if (lo < closed) begin
          if (op != OP_CONTAIN || (!(val < low_st[lo]) && !(high_st[lo] < val)))
            report_bucket(r, lo);
        end
        return 1;
      end
      OP_TOTALS: begin
        ex = (extra < closed) ? extra : closed;
        r.kind           = KIND_TOTALS;
        r.total_rows     = grand_rows;
        r.total_distinct = 17'(share * closed + ex);
        return 1;
      end
      OP_CLEAR: begin
        clear_model();
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // observe transfers at each rising edge
  always @(posedge clk) begin
    hist_result_t exp_r, got_r;
    if (rst) begin
      distinct_total_reg = 17'd1;
      bucket_limit_reg   = 9'd256;
      clear_model();
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_DISTINCT_TOTAL) distinct_total_reg = cfg_data;
        else bucket_limit_reg = cfg_data[8:0];
      end
      if (rsp.valid && rsp.ready) begin
        got_r = '{kind: kind_t'(rsp.kind), found: rsp.found,
                  bucket_id: rsp.bucket_id, bucket_low: rsp.bucket_low,
                  bucket_high: rsp.bucket_high, bucket_rows: rsp.bucket_rows,
                  bucket_distinct: rsp.bucket_distinct, total_rows: rsp.total_rows,
                  total_distinct: rsp.total_distinct};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %p", $realtime, got_r);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("kind", 64'(exp_r.kind), 64'(got_r.kind));
          check_field("found", 64'(exp_r.found), 64'(got_r.found));
          check_field("bucket_id", 64'(exp_r.bucket_id), 64'(got_r.bucket_id));
          check_field("bucket_low", exp_r.bucket_low, got_r.bucket_low);
          check_field("bucket_high", exp_r.bucket_high, got_r.bucket_high);
          check_field("bucket_rows", 64'(exp_r.bucket_rows), 64'(got_r.bucket_rows));
          check_field("bucket_distinct", 64'(exp_r.bucket_distinct),
                      64'(got_r.bucket_distinct));
          check_field("total_rows", 64'(exp_r.total_rows), 64'(got_r.total_rows));
          check_field("total_distinct", 64'(exp_r.total_distinct),
                      64'(got_r.total_distinct));
        end
      end
      if (req.valid && req.ready) begin
        if (predict_histogram(req.opcode, req.value, req.occurrences, exp_r))
          expected_results.push_back(exp_r);
      end
    end
    pending = expected_results.size();
  end

  initial begin
    errors  = 0;
    pending = 0;
  end

endmodule

`default_nettype wire

@@ bench/equal_distinct_histogram_engine_unit_tb.sv @@
// ----------------------------------------------------------------------------
// equal_distinct_histogram_engine_unit_tb
// Drives directed and random histogram builds, lookups, totals and clears
// with random idling on both channels and one long response hold-off; the
// checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module equal_distinct_histogram_engine_unit_tb;
  import edh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int TARGET_ITEMS = 1850;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  int errors, pending;
  int items_sent = 0;
  int hold_off = 0;
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;
  logic signed [63:0] loaded_vals[$];
  logic signed [63:0] next_val;

  edh_req_if req_ch ();
  edh_rsp_if rsp_ch ();

  equal_distinct_histogram_engine_unit u_dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  edh_checker u_checker (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_LOAD;
    req_ch.value = '0;
    req_ch.occurrences = '0;
    rsp_ch.ready = 1'b0;
  end

  // response side: random stalls, a steady stretch and the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready = 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = receiver_steady || ($urandom_range(99) >= 35);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    int quiet;
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet = 0;
    end else if (++quiet >= STALL_LIMIT) begin
      $display("[equal_distinct_histogram_engine_unit] ERROR");
      $finish;
    end
  end

  function automatic logic signed [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_occ();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // one request transfer; called and returns at a falling edge
  task automatic send_item(logic [2:0] op, logic signed [63:0] val, logic [31:0] occ);
    while (!sender_steady && $urandom_range(99) < 35) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.opcode = op;
    req_ch.value = val;
    req_ch.occurrences = occ;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    sender_steady = (items_sent >= 600 && items_sent < 900);
    receiver_steady = sender_steady;
    if (items_sent == 1000) hold_off = 300;
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic load_next();
    next_val = next_val + $urandom_range(1, ($urandom_range(3) == 0) ? 100000 : 5);
    loaded_vals.push_back(next_val);
    send_item(OP_LOAD, next_val, rand_occ());
  endtask

  task automatic lookup_random();
    logic signed [63:0] v;
    logic [2:0] op;
    op = 3'(OP_CONTAIN + $urandom_range(2));
    case ($urandom_range(5))
      0: v = rand64();
      1: v = ($urandom_range(1)) ? 64'sh7FFF_FFFF_FFFF_FFFF : 64'sh8000_0000_0000_0000;
      default: begin
        v = (loaded_vals.size() != 0) ?
            loaded_vals[$urandom_range(loaded_vals.size() - 1)] : rand64();
        v = v + $signed($urandom_range(2)) - 1;
      end
    endcase
    send_item(op, v, rand_occ());
  endtask

  // one build under fresh register settings, with interleaved queries and noise
  task automatic random_build();
    int dt, bl, n;
    case ($urandom_range(19))
      0: dt = 0;
      1: dt = $urandom_range(300, 500);
      2: dt = 131071;
      default: dt = $urandom_range(1, 40);
    endcase
    case ($urandom_range(9))
      0: bl = 0;
      1: bl = 256;
      2: bl = 511;
      3: bl = $urandom_range(1, 511);
      default: bl = $urandom_range(1, 16);
    endcase
    wait_idle();
    write_reg(CFG_DISTINCT_TOTAL, CFG_W'(dt));
    write_reg(CFG_BUCKET_LIMIT, CFG_W'(bl));
    send_item(OP_CLEAR, rand64(), rand_occ());
    loaded_vals.delete();
    next_val = ($urandom_range(3) == 0) ? rand64() : $signed(64'($urandom)) - 64'sd100000;
    n = ((dt > 600) ? 60 : dt) + $urandom_range(0, 3);
    while (n > 0 && items_sent < TARGET_ITEMS) begin
      case ($urandom_range(19))
        0, 1, 2, 3: lookup_random();
        4: send_item(OP_TOTALS, rand64(), rand_occ());
        5: send_item(($urandom_range(1)) ? OP_SPARE6 : OP_SPARE7, rand64(), rand_occ());
        6: send_item(OP_LOAD, rand64(), rand_occ());
        default: begin
          load_next();
          n--;
        end
      endcase
    end
    repeat ($urandom_range(2, 6)) lookup_random();
    send_item(OP_TOTALS, rand64(), rand_occ());
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // empty histogram, then a single-bucket build under reset settings
    send_item(OP_TOTALS, '0, '0);
    send_item(OP_CONTAIN, 64'sh8000_0000_0000_0000, '0);
    send_item(OP_UPPER, 64'sh7FFF_FFFF_FFFF_FFFF, '0);
    send_item(OP_LOAD, 64'sh8000_0000_0000_0000, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 64'sh0000_0000_0000_0005, 32'd7);
    send_item(OP_CONTAIN, 64'sh8000_0000_0000_0000, '0);
    send_item(OP_CONTAIN, 64'sh8000_0000_0000_0001, '0);
    send_item(OP_LOWER, 64'sh7FFF_FFFF_FFFF_FFFF, '0);
    send_item(OP_UPPER, 64'sh8000_0000_0000_0000, '0);
    send_item(OP_LOWER, 64'sh8000_0000_0000_0000, '0);
    send_item(OP_TOTALS, '1, '1);
    send_item(OP_SPARE6, '1, '1);
    send_item(OP_SPARE7, '0, '0);
    send_item(OP_CLEAR, '0, '0);

    // distinct total above the maximum with bucket limit zero
    wait_idle();
    write_reg(CFG_DISTINCT_TOTAL, 17'h1FFFF);
    write_reg(CFG_BUCKET_LIMIT, 17'd0);
    send_item(OP_LOAD, 64'sh7FFF_FFFF_FFFF_FFF0, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 64'sh7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_TOTALS, '0, '0);
    send_item(OP_CLEAR, '0, '0);

    // zero distinct total ignores loads
    wait_idle();
    write_reg(CFG_DISTINCT_TOTAL, 17'd0);
    send_item(OP_LOAD, 64'sd3, 32'd9);
    send_item(OP_TOTALS, '0, '0);

    // limit above bucket count, values out of order
    wait_idle();
    write_reg(CFG_DISTINCT_TOTAL, 17'd3);
    write_reg(CFG_BUCKET_LIMIT, 17'd511);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_LOAD, 64'sd50, 32'd1);
    send_item(OP_LOAD, -64'sd20, 32'd2);
    send_item(OP_LOAD, 64'sd10, 32'd3);
    send_item(OP_LOWER, 64'sd0, '0);
    send_item(OP_TOTALS, '0, '0);

    while (items_sent < TARGET_ITEMS) random_build();

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[equal_distinct_histogram_engine_unit] OK");
    end else begin
      $display("[equal_distinct_histogram_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
